// File: design/deqs_pkg.sv
// ----------------------------------------------------------------------------
// deqs_pkg
// Shared types and codes for the double-ended queue with search: operation
// and status codes, default sizes, and the request and result records.
// ----------------------------------------------------------------------------
package deqs_pkg;

	// Default sizes handed to the top level.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Field widths of the stream items.
	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int OUT_BITS = STATUS_W + VALUE_W + POS_W + COUNT_W + 1 + VALUE_W + VALUE_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_ADD_FRONT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_BACK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TAKE_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TAKE_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

	// Status codes reported with every result.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

	// One operation request.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [VALUE_W-1:0] value;
	} req_t;

	// One result, laid out so that status sits in the lowest bits.
	typedef struct packed {
		logic [VALUE_W-1:0]  back_value;
		logic [VALUE_W-1:0]  front_value;
		logic                is_empty;
		logic [COUNT_W-1:0]  count;
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  popped_value;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

// File: design/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Push and unused-mode items go from idle straight to done; pops pass through
// a fetch state, since the new end word is read back from the word memory.
// A search compares one held word per cycle, front first, and stops at the
// first hit or after the last held word; a search of an empty queue goes straight to done.
// The output register lets the next item be taken while a result waits.
// Reset clears the pointers, count and handshakes; the memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
	parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [deqs_pkg::VALUE_W-1:0] s_tdata,  // value
	input  logic [deqs_pkg::MODE_W-1:0]  s_tuser,  // mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status, popped_value, position, count, is_empty, front_value, back_value
	output logic [deqs_pkg::OUT_W-1:0]   m_tdata
);
	import deqs_pkg::*;

	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             res_ready;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	// Input item unpacking.
	assign req.mode  = s_tuser;
	assign req.value = s_tdata;

	deqs_core #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register between the engine and the result stream.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
			if (res_valid) begin
				m_tdata_q <= OUT_W'(res);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A finished result waits in the engine until the output register frees.
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result left the engine while the output register was full");

	// A result handed over always shows up on the stream in the next cycle.
	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid_q)
		else $error("handed-over result missing from the output register");

	// An empty queue reports zero end words.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_empty |-> res.front_value == '0 && res.back_value == '0)
		else $error("empty queue reported nonzero end words");

	// A pop from an empty queue removes nothing.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == STAT_EMPTY |-> res.popped_value == '0 && res.is_empty)
		else $error("pop from empty queue reported a word");

endmodule

// File: design/deqs_core.sv
// ----------------------------------------------------------------------------
// deqs_core
// Ring-buffer engine: a single synchronous word memory with front and back
// pointers, cached front and back words, and a one-entry-per-cycle search scan.
// ----------------------------------------------------------------------------
module deqs_core #(
	parameter int DEPTH      = deqs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deqs_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  deqs_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output deqs_pkg::res_t res
);
	import deqs_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_DONE
	} state_t;

	// Word memory with one write and one registered read port.
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  we;
	logic [IW-1:0]         wr_addr;
	logic [IW-1:0]         rd_addr;

	state_t                state_q;
	logic [IW-1:0]         front_idx_q;
	logic [IW-1:0]         back_idx_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] front_word_q;
	logic [DATA_WIDTH-1:0] back_word_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [IW-1:0]         scan_ptr_q;
	logic [CW-1:0]         scan_k_q;
	logic                  fetch_back_q;
	logic [STATUS_W-1:0]   status_q;
	logic [DATA_WIDTH-1:0] popped_q;
	logic [CW-1:0]         pos_q;

	logic [DATA_WIDTH-1:0] in_word;
	logic [IW-1:0]         front_up;
	logic [IW-1:0]         front_dn;
	logic [IW-1:0]         back_up;
	logic [IW-1:0]         back_dn;
	logic [IW-1:0]         back_dn2;
	logic                  accept;
	logic                  q_full;
	logic                  q_empty;
	logic                  scan_hit;
	logic                  scan_last;

	function automatic logic [IW-1:0] idx_up(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dn(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] w);
		return VALUE_W'({{VALUE_W{w[DATA_WIDTH-1]}}, w});
	endfunction

	// Pointer neighbors and queue status.
	assign in_word   = DATA_WIDTH'({{DATA_WIDTH{req.value[VALUE_W-1]}}, req.value});
	assign front_up  = idx_up(front_idx_q);
	assign front_dn  = idx_dn(front_idx_q);
	assign back_up   = idx_up(back_idx_q);
	assign back_dn   = idx_dn(back_idx_q);
	assign back_dn2  = idx_dn(back_dn);
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign q_full    = (count_q == FULL_CNT);
	assign q_empty   = (count_q == '0);
	assign scan_hit  = (rd_data_q == key_q);
	assign scan_last = ((CW + 1)'(scan_k_q) + 1'b1) == (CW + 1)'(count_q);

	// Memory address and write enable selection.
	always_comb begin
		we      = 1'b0;
		wr_addr = back_idx_q;
		rd_addr = scan_ptr_q;
		if (state_q == S_IDLE) begin
			case (req.mode)
				MODE_ADD_FRONT: begin
					we      = accept && !q_full;
					wr_addr = front_dn;
				end
				MODE_ADD_BACK: begin
					we      = accept && !q_full;
					wr_addr = back_idx_q;
				end
				MODE_TAKE_FRONT: rd_addr = front_up;
				MODE_TAKE_BACK:  rd_addr = back_dn2;
				MODE_SEARCH:     rd_addr = front_idx_q;
				default:         rd_addr = scan_ptr_q;
			endcase
		end
	end

	// Word memory.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= in_word;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Operation sequencer with pointers, cached ends and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_idx_q  <= '0;
			back_idx_q   <= '0;
			count_q      <= '0;
			front_word_q <= '0;
			back_word_q  <= '0;
			key_q        <= '0;
			scan_ptr_q   <= '0;
			scan_k_q     <= '0;
			fetch_back_q <= 1'b0;
			status_q     <= STAT_OK;
			popped_q     <= '0;
			pos_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= STAT_OK;
						popped_q <= '0;
						pos_q    <= '0;
						state_q  <= S_DONE;
						case (req.mode)
							MODE_ADD_FRONT: begin
								if (q_full) begin
									status_q <= STAT_FULL;
								end else begin
									front_idx_q  <= front_dn;
									count_q      <= count_q + 1'b1;
									front_word_q <= in_word;
									if (q_empty) begin
										back_word_q <= in_word;
									end
								end
							end
							MODE_ADD_BACK: begin
								if (q_full) begin
									status_q <= STAT_FULL;
								end else begin
									back_idx_q  <= back_up;
									count_q     <= count_q + 1'b1;
									back_word_q <= in_word;
									if (q_empty) begin
										front_word_q <= in_word;
									end
								end
							end
							MODE_TAKE_FRONT: begin
								if (q_empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									popped_q     <= front_word_q;
									front_idx_q  <= front_up;
									count_q      <= count_q - 1'b1;
									fetch_back_q <= 1'b0;
									state_q      <= S_FETCH;
								end
							end
							MODE_TAKE_BACK: begin
								if (q_empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									popped_q     <= back_word_q;
									back_idx_q   <= back_dn;
									count_q      <= count_q - 1'b1;
									fetch_back_q <= 1'b1;
									state_q      <= S_FETCH;
								end
							end
							MODE_SEARCH: begin
								key_q    <= in_word;
								status_q <= STAT_NOT_FOUND;
								if (!q_empty) begin
									scan_ptr_q <= front_up;
									scan_k_q   <= '0;
									state_q    <= S_SCAN;
								end
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_FETCH: begin
					// The new end word arrives from memory after a pop.
					if (fetch_back_q) begin
						back_word_q <= rd_data_q;
					end else begin
						front_word_q <= rd_data_q;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					// One held word is compared per cycle, front first.
					if (scan_hit) begin
						status_q <= STAT_OK;
						pos_q    <= scan_k_q;
						state_q  <= S_DONE;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end else begin
						scan_k_q   <= scan_k_q + 1'b1;
						scan_ptr_q <= idx_up(scan_ptr_q);
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result record, built from the registers once the operation is done.
	always_comb begin
		res_valid        = (state_q == S_DONE);
		res.status       = status_q;
		res.popped_value = to_out(popped_q);
		res.position     = POS_W'({{POS_W{1'b0}}, pos_q});
		res.count        = COUNT_W'({{COUNT_W{1'b0}}, count_q});
		res.is_empty     = q_empty;
		res.front_value  = q_empty ? '0 : to_out(front_word_q);
		res.back_value   = q_empty ? '0 : to_out(back_word_q);
	end

endmodule
